@@ src/m3inv_pkg.sv @@
// Shared widths and types for the 3x3 matrix inverse pipeline.
// No dependencies; imported by matrix3x3_inverse.
`default_nettype none

package m3inv_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LANES   = 9;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned COF_W   = PROD_W + 1;
  localparam int unsigned ACOF_W  = PROD_W;
  localparam int unsigned PART_W  = COF_W;
  localparam int unsigned TERM_W  = PART_W + DATA_W + 1;
  localparam int unsigned DET_W   = TERM_W + 2;
  localparam int unsigned DABS_W  = TERM_W;
  localparam int unsigned Q_W     = DATA_W;
  localparam int unsigned TDATA_W = LANES * DATA_W;
  localparam int unsigned TUSER_W = 2;

  localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] entry_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic [DABS_W-1:0]        dabs_t;
  typedef logic [Q_W-1:0]           quot_t;

  typedef struct packed {
    logic sing;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] big;
  } flags_t;

endpackage

`default_nettype wire

@@ src/matrix3x3_inverse.sv @@
// Top level of the 3x3 fixed-point matrix inverse (adjugate over determinant).
// Depends on m3inv_pkg for widths and types.
`default_nettype none

// Takes one 3x3 matrix of signed fixed-point entries per cycle and returns its
// inverse one per cycle unless the result side stalls. It has one multiply
// stage for the minors, one for the cofactors, three for the exact determinant,
// one for magnitudes, 32 restoring-divider stages (one quotient bit per stage,
// nine lanes side by side) and one output register. A stall on the result side
// holds every stage. A zero determinant gives zeros with the singular flag;
// quotients beyond the signed 32-bit range saturate and set the overflow flag.
module matrix3x3_inverse #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each, lowest first)
  input  wire  [m3inv_pkg::TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // b00, b01, b02, b10, b11, b12, b20, b21, b22 (32 bits each, lowest first)
  output logic [m3inv_pkg::TDATA_W-1:0]  m_axis_tdata,
  // bit 0 singular, bit 1 overflow
  output logic [m3inv_pkg::TUSER_W-1:0]  m_axis_tuser
);

  import m3inv_pkg::*;

  localparam int unsigned NUM_W  = ACOF_W + 2 * FRAC_BITS;
  localparam int unsigned NHI_W  = NUM_W - Q_W;
  localparam int unsigned STEPS  = Q_W;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  entry_t a [LANES];
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      a[k] = entry_t'(s_axis_tdata[k*DATA_W +: DATA_W]);
    end
  end

  // stage 1: minor products
  logic signed [PROD_W-1:0] pa_q [LANES];
  logic signed [PROD_W-1:0] pb_q [LANES];
  entry_t a0s1_q [3];
  logic v1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pa_q[r*3+c] <= a[((r+1)%3)*3 + (c+1)%3] * a[((r+2)%3)*3 + (c+2)%3];
          pb_q[r*3+c] <= a[((r+1)%3)*3 + (c+2)%3] * a[((r+2)%3)*3 + (c+1)%3];
        end
      end
      for (int c = 0; c < 3; c++) begin
        a0s1_q[c] <= a[c];
      end
    end
  end

  // stage 2: cofactors
  cof_t cof2_q [LANES];
  entry_t a0s2_q [3];
  logic v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        cof2_q[k] <= COF_W'(pa_q[k]) - COF_W'(pb_q[k]);
      end
      a0s2_q <= a0s1_q;
    end
  end

  // stage 3: determinant partial products
  logic signed [PART_W-1:0] pl_q [3];
  logic signed [PART_W-1:0] ph_q [3];
  cof_t cof3_q [LANES];
  logic v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pl_q[c] <= $signed({1'b0, cof2_q[c][DATA_W-1:0]}) * a0s2_q[c];
        ph_q[c] <= $signed(cof2_q[c][COF_W-1:DATA_W]) * a0s2_q[c];
      end
      cof3_q <= cof2_q;
    end
  end

  // stage 4: determinant terms
  logic signed [TERM_W-1:0] term_q [3];
  cof_t cof4_q [LANES];
  logic v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        term_q[c] <= (TERM_W'(ph_q[c]) <<< DATA_W) + TERM_W'(pl_q[c]);
      end
      cof4_q <= cof3_q;
    end
  end

  // stage 5: determinant sum, cofactor magnitudes
  logic signed [DET_W-1:0] det_q;
  logic [ACOF_W-1:0] acof_q [LANES];
  logic [LANES-1:0] cneg_q;
  logic v5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= DET_W'(term_q[0]) + DET_W'(term_q[1]) + DET_W'(term_q[2]);
      for (int k = 0; k < LANES; k++) begin
        cneg_q[k] <= cof4_q[k][COF_W-1];
        acof_q[k] <= cof4_q[k][COF_W-1] ? ACOF_W'(-cof4_q[k]) : ACOF_W'(cof4_q[k]);
      end
    end
  end

  // stage 6: determinant magnitude, numerators in output order
  dabs_t dabs6_q;
  logic [NUM_W-1:0] num_q [LANES];
  logic [LANES-1:0] neg6_q;
  logic sing6_q;
  logic v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dabs6_q <= det_q[DET_W-1] ? DABS_W'(-det_q) : DABS_W'(det_q);
      sing6_q <= (det_q == '0);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          num_q[i*3+j]  <= NUM_W'(acof_q[j*3+i]) << (2 * FRAC_BITS);
          neg6_q[i*3+j] <= cneg_q[j*3+i] ^ det_q[DET_W-1];
        end
      end
    end
  end

  // divider stages: one quotient bit each
  dabs_t   rem_q  [STEPS][LANES];
  quot_t   nlo_q  [STEPS][LANES];
  quot_t   quo_q  [STEPS][LANES];
  dabs_t   dv_q   [STEPS];
  flags_t  fl_q   [STEPS];
  logic [STEPS-1:0] dvld_q;

  dabs_t  rem_in [STEPS][LANES];
  quot_t  nlo_in [STEPS][LANES];
  quot_t  quo_in [STEPS][LANES];
  dabs_t  dv_in  [STEPS];
  flags_t fl_in  [STEPS];
  dabs_t  rem_d  [STEPS][LANES];
  quot_t  nlo_d  [STEPS][LANES];
  quot_t  quo_d  [STEPS][LANES];

  always_comb begin
    logic [NHI_W-1:0] nhi;
    logic [DABS_W:0]  t;
    logic             ge;
    dv_in[0]      = dabs6_q;
    fl_in[0].sing = sing6_q;
    fl_in[0].neg  = neg6_q;
    for (int l = 0; l < LANES; l++) begin
      nhi = num_q[l][NUM_W-1:Q_W];
      fl_in[0].big[l] = ({{(DABS_W-NHI_W){1'b0}}, nhi} >= dabs6_q);
      rem_in[0][l] = DABS_W'(nhi);
      nlo_in[0][l] = num_q[l][Q_W-1:0];
      quo_in[0][l] = '0;
    end
    for (int k = 1; k < STEPS; k++) begin
      dv_in[k] = dv_q[k-1];
      fl_in[k] = fl_q[k-1];
      for (int l = 0; l < LANES; l++) begin
        rem_in[k][l] = rem_q[k-1][l];
        nlo_in[k][l] = nlo_q[k-1][l];
        quo_in[k][l] = quo_q[k-1][l];
      end
    end
    for (int k = 0; k < STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        t  = {rem_in[k][l], nlo_in[k][l][Q_W-1]};
        ge = (t >= {1'b0, dv_in[k]});
        rem_d[k][l] = ge ? DABS_W'(t - {1'b0, dv_in[k]}) : DABS_W'(t);
        nlo_d[k][l] = {nlo_in[k][l][Q_W-2:0], 1'b0};
        quo_d[k][l] = {quo_in[k][l][Q_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        dv_q[k] <= dv_in[k];
        fl_q[k] <= fl_in[k];
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          nlo_q[k][l] <= nlo_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
    end
  end

  // output: sign, saturation, singular zeroing
  logic [TDATA_W-1:0] tdata_d;
  logic [TUSER_W-1:0] tuser_d;

  always_comb begin
    flags_t     f;
    quot_t      q;
    logic       sat;
    logic       ovf;
    f   = fl_q[STEPS-1];
    ovf = 1'b0;
    sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      q = quo_q[STEPS-1][l];
      if (f.sing) begin
        tdata_d[l*DATA_W +: DATA_W] = '0;
      end else if (!f.neg[l]) begin
        sat = f.big[l] || q[Q_W-1];
        ovf = ovf | sat;
        tdata_d[l*DATA_W +: DATA_W] = sat ? SAT_POS : q;
      end else begin
        sat = f.big[l] || (q > SAT_NEG);
        ovf = ovf | sat;
        tdata_d[l*DATA_W +: DATA_W] = sat ? SAT_NEG : quot_t'(-q);
      end
    end
    tuser_d = {ovf, f.sing};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= tdata_d;
      m_axis_tuser <= tuser_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      v4_q          <= 1'b0;
      v5_q          <= 1'b0;
      v6_q          <= 1'b0;
      dvld_q        <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1_q          <= s_axis_tvalid;
      v2_q          <= v1_q;
      v3_q          <= v2_q;
      v4_q          <= v3_q;
      v5_q          <= v4_q;
      v6_q          <= v5_q;
      dvld_q        <= {dvld_q[STEPS-2:0], v6_q};
      m_axis_tvalid <= dvld_q[STEPS-1];
    end
  end

endmodule

`default_nettype wire
